FILE: rtl/geo_polygon_area_shoelace_core_macros.svh
// ----------------------------------------------------------------------------
// geo polygon area assertion macros
// shared assertion wrappers, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef GEO_POLYGON_AREA_SHOELACE_CORE_MACROS_SVH
`define GEO_POLYGON_AREA_SHOELACE_CORE_MACROS_SVH

// same-cycle implication
`define GPAS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GPAS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/gpas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpas_pkg
// shared constants, types and tables of the polygon area core
// ----------------------------------------------------------------------------
package gpas_pkg;

   // parameter defaults
   localparam int SUM_BITS_DEF  = 64;
   localparam int COS_STEPS_DEF = 16;

   // cordic start value, 0.60725293500888 in q1.17
   localparam logic [16:0] CORDIC_X0    = 17'd79594;
   // earth radius squared times degree scale squared times one half, q46
   localparam logic [32:0] AREA_K       = 33'd4360057603;
   localparam logic [17:0] COS_MAX      = 18'h3FFFF;
   localparam logic [49:0] AREA_MAX     = {50{1'b1}};
   localparam logic [30:0] QUARTER_TURN = 31'd900000000;
   localparam logic [30:0] HALF_TURN    = 31'd1800000000;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic cos_start;
      logic cos_step;
      logic mul;
      logic combine;
      logic accum;
      logic scale;
      logic part;
      logic rsp_load;
   } gpas_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic first_vertex;
      logic last_vertex;
      logic short_poly;
      logic cos_done;
      logic part_done;
      logic rsp_free;
   } gpas_sts_type;

   // arctangent of 2^-i in units of 1e-7 degree
   function automatic logic [28:0] atan_deg7(input logic [4:0] idx);
      logic [28:0] val;
      unique case (idx)
         5'd0:  val = 29'd450000000;
         5'd1:  val = 29'd265650512;
         5'd2:  val = 29'd140362435;
         5'd3:  val = 29'd71250163;
         5'd4:  val = 29'd35763344;
         5'd5:  val = 29'd17899106;
         5'd6:  val = 29'd8951737;
         5'd7:  val = 29'd4476142;
         5'd8:  val = 29'd2238105;
         5'd9:  val = 29'd1119057;
         5'd10: val = 29'd559529;
         5'd11: val = 29'd279765;
         5'd12: val = 29'd139882;
         5'd13: val = 29'd69941;
         5'd14: val = 29'd34971;
         5'd15: val = 29'd17485;
         5'd16: val = 29'd8743;
         5'd17: val = 29'd4371;
         5'd18: val = 29'd2186;
         5'd19: val = 29'd1093;
         5'd20: val = 29'd546;
         5'd21: val = 29'd273;
         5'd22: val = 29'd137;
         5'd23: val = 29'd68;
         default: val = 29'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/geo_polygon_area_shoelace_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_polygon_area_shoelace_core
// polygon area in square metres from a stream of lon/lat vertices
// ----------------------------------------------------------------------------
// One vertex per beat; the first beat of a polygon becomes the origin and
// tlast closes the ring, which yields one result beat (area and status).
// The block works on one vertex at a time through a shared sequencer: a
// first vertex runs COS_STEPS CORDIC rotations (one rotation per cycle),
// every later vertex goes through offset and product, combine and sum,
// and a closing vertex of three or more adds the four 32 x 32 partial
// products of the area scaling, plus any wait for the result register.
// A result register parts the two sides, so the next polygon's vertices
// flow while a result waits to be taken.
// ----------------------------------------------------------------------------
`include "geo_polygon_area_shoelace_core_macros.svh"

module geo_polygon_area_shoelace_core #(
   parameter int SUM_BITS  = gpas_pkg::SUM_BITS_DEF,
   parameter int COS_STEPS = gpas_pkg::COS_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // lon [31:0], lat [62:32], zero [63]
   input  logic        req_tlast,   // last_vertex
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // area_sq_m [49:0], zero [55:50]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   gpas_pkg::gpas_cmd_type cmd;
   gpas_pkg::gpas_sts_type sts;
   logic [49:0] area;
   logic [1:0]  status;

   gpas_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gpas_datapath #(
      .SUM_BITS  (SUM_BITS),
      .COS_STEPS (COS_STEPS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_lon     (req_tdata[31:0]),
      .in_lat     (req_tdata[62:32]),
      .in_last    (req_tlast),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_area   (area),
      .rsp_status (status)
   );

   assign rsp_tdata = {6'd0, area};
   assign rsp_tuser = status;

   // a short polygon never reports an area
   `GPAS_ASSERT_IMPLY(a_short_zero, rsp_tvalid && (rsp_tuser == gpas_pkg::STATUS_SHORT), rsp_tdata == 56'd0, "short polygon with nonzero area")
   // one vertex at a time: busy right after a beat is taken
   `GPAS_ASSERT_NEXT(a_busy_after_beat, req_tvalid && req_tready, !req_tready, "vertex taken while busy")
   // a new result never overwrites one still waiting
   `GPAS_ASSERT_IMPLY(a_no_overwrite, cmd.rsp_load, !rsp_tvalid || rsp_tready, "result overwritten")

endmodule

FILE: rtl/gpas_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpas_datapath
// vertex offsets, cross products, shoelace sum, cordic cosine, area scaling
// ----------------------------------------------------------------------------
module gpas_datapath #(
   parameter int SUM_BITS  = gpas_pkg::SUM_BITS_DEF,
   parameter int COS_STEPS = gpas_pkg::COS_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gpas_pkg::gpas_cmd_type cmd,
   output gpas_pkg::gpas_sts_type sts,
   input  logic [31:0]          in_lon,
   input  logic [30:0]          in_lat,
   input  logic                 in_last,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [49:0]          rsp_area,
   output logic [1:0]           rsp_status
);

   localparam int MAG_W  = SUM_BITS - 1;
   localparam int STEP_W = (COS_STEPS > 1) ? $clog2(COS_STEPS) : 1;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COS_STEPS - 1);
   localparam logic [64:0] SUM_LIMIT = 65'({MAG_W{1'b1}});

   // captured beat
   logic [31:0] item_lon_ff;
   logic [30:0] item_lat_ff;
   logic        item_last_ff;
   logic        first_ff, first_in;
   logic [1:0]  vcount_ff, vcount_in;

   // polygon state
   logic [31:0]        origin_lon_ff;
   logic [30:0]        origin_lat_ff;
   logic signed [32:0] prev_dlon_ff;
   logic signed [31:0] prev_dlat_ff;
   logic               sum_neg_ff, sum_neg_in;
   logic [MAG_W-1:0]   sum_mag_ff, sum_mag_in;
   logic               ovf_ff, ovf_in;
   logic [17:0]        origin_cos_ff;

   // product and combine stages
   logic signed [64:0] p1_ff, p2_ff;
   logic               cn_ff, cn_in;
   logic [63:0]        cm_ff, cm_in;

   // cordic state
   logic signed [19:0]  x_ff, y_ff, x_in, y_in;
   logic signed [31:0]  z_ff, z_in;
   logic [STEP_W-1:0]   step_ff;

   // area scaling
   logic [50:0]  f_ff;
   logic [127:0] acc_ff;
   logic [1:0]   part_ff;

   // result register
   logic        rsp_valid_ff;
   logic [49:0] rsp_area_ff, rsp_area_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // offsets from the origin and the two cross products
   logic signed [32:0] dlon;
   logic signed [31:0] dlat;
   logic signed [64:0] p1_in, p2_in;
   assign dlon  = signed'({item_lon_ff[31], item_lon_ff}) -
                  signed'({origin_lon_ff[31], origin_lon_ff});
   assign dlat  = signed'({item_lat_ff[30], item_lat_ff}) -
                  signed'({origin_lat_ff[30], origin_lat_ff});
   assign p1_in = prev_dlat_ff * dlon;
   assign p2_in = dlat * prev_dlon_ff;

   // sign-magnitude combine of p1 - p2, carry saturates
   logic signed [64:0] p1_neg, p2_neg;
   logic [63:0]        m1, m2;
   logic               n1, n2;
   logic [64:0]        csum;
   assign p1_neg = -p1_ff;
   assign p2_neg = -p2_ff;
   assign m1 = p1_ff[64] ? p1_neg[63:0] : p1_ff[63:0];
   assign m2 = p2_ff[64] ? p2_neg[63:0] : p2_ff[63:0];
   assign n1 = p1_ff[64];
   assign n2 = !p2_ff[64] && (p2_ff != 65'sd0);
   assign csum = {1'b0, m1} + {1'b0, m2};

   always_comb begin
      if (n1 == n2) begin
         cn_in = n1;
         cm_in = csum[64] ? {64{1'b1}} : csum[63:0];
      end else if (m1 >= m2) begin
         cn_in = n1;
         cm_in = m1 - m2;
      end else begin
         cn_in = n2;
         cm_in = m2 - m1;
      end
   end

   // running sum update with symmetric saturation
   logic [64:0] am, acc_raw;
   logic        acc_neg;
   assign am = 65'(sum_mag_ff);

   always_comb begin
      if (sum_neg_ff == cn_ff) begin
         acc_raw = am + {1'b0, cm_ff};
         acc_neg = sum_neg_ff;
      end else if (am >= {1'b0, cm_ff}) begin
         acc_raw = am - {1'b0, cm_ff};
         acc_neg = sum_neg_ff;
      end else begin
         acc_raw = {1'b0, cm_ff} - am;
         acc_neg = cn_ff;
      end
   end

   always_comb begin
      sum_neg_in = sum_neg_ff;
      sum_mag_in = sum_mag_ff;
      ovf_in     = ovf_ff;
      if (cmd.cos_start) begin
         sum_neg_in = 1'b0;
         sum_mag_in = '0;
         ovf_in     = 1'b0;
      end else if (cmd.accum) begin
         sum_neg_in = acc_neg;
         if (acc_raw > SUM_LIMIT) begin
            sum_mag_in = {MAG_W{1'b1}};
            ovf_in     = 1'b1;
         end else begin
            sum_mag_in = acc_raw[MAG_W-1:0];
         end
      end
   end

   // cordic start angle: |lat| reflected about a quarter turn
   logic [30:0]        lat_abs;
   logic signed [31:0] z_start;
   assign lat_abs = item_lat_ff[30] ? (~item_lat_ff + 31'd1) : item_lat_ff;
   assign z_start = (lat_abs > gpas_pkg::QUARTER_TURN) ?
                    signed'({1'b0, gpas_pkg::HALF_TURN - lat_abs}) :
                    signed'({1'b0, lat_abs});

   // one cordic rotation per cycle
   logic signed [19:0] x_sh, y_sh;
   logic signed [31:0] atan_s;
   logic [17:0]        cos_clamp;
   assign x_sh   = x_ff >>> step_ff;
   assign y_sh   = y_ff >>> step_ff;
   assign atan_s = signed'({3'b000, gpas_pkg::atan_deg7(5'(step_ff))});

   always_comb begin
      if (!z_ff[31]) begin
         x_in = x_ff - y_sh;
         y_in = y_ff + x_sh;
         z_in = z_ff - atan_s;
      end else begin
         x_in = x_ff + y_sh;
         y_in = y_ff - x_sh;
         z_in = z_ff + atan_s;
      end
   end

   always_comb begin
      if (x_in[19])
         cos_clamp = '0;
      else if (x_in[18])
         cos_clamp = gpas_pkg::COS_MAX;
      else
         cos_clamp = x_in[17:0];
   end

   // area partial products, 32 by 32 bits a cycle
   logic [63:0]  area_a;
   logic [31:0]  op_a, op_b;
   logic [63:0]  prod;
   logic [127:0] prod_sh;
   assign area_a  = 64'(sum_mag_ff);
   assign op_a    = part_ff[0] ? area_a[63:32] : area_a[31:0];
   assign op_b    = part_ff[1] ? 32'(f_ff[50:32]) : f_ff[31:0];
   assign prod    = op_a * op_b;
   assign prod_sh = 128'(prod) << ({6'd0, part_ff[0]} + {6'd0, part_ff[1]}) * 7'd32;

   // vertex count
   always_comb begin
      first_in  = first_ff;
      vcount_in = vcount_ff;
      if (cmd.capture) begin
         first_in  = (vcount_ff == 2'd0);
         vcount_in = (vcount_ff == 2'd3) ? 2'd3 : vcount_ff + 2'd1;
      end else if (cmd.rsp_load) begin
         vcount_in = 2'd0;
      end
   end

   // result value
   always_comb begin
      if (vcount_ff != 2'd3) begin
         rsp_area_in   = '0;
         rsp_status_in = gpas_pkg::STATUS_SHORT;
      end else begin
         rsp_area_in   = (acc_ff[127:113] != '0) ? gpas_pkg::AREA_MAX : acc_ff[112:63];
         rsp_status_in = ovf_ff ? gpas_pkg::STATUS_OVERFLOW : gpas_pkg::STATUS_OK;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= 2'd0;
         first_ff     <= 1'b0;
         sum_neg_ff   <= 1'b0;
         sum_mag_ff   <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         part_ff      <= 2'd0;
      end else begin
         vcount_ff  <= vcount_in;
         first_ff   <= first_in;
         sum_neg_ff <= sum_neg_in;
         sum_mag_ff <= sum_mag_in;
         ovf_ff     <= ovf_in;
         if (cmd.rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (cmd.cos_start)
            step_ff <= '0;
         else if (cmd.cos_step)
            step_ff <= step_ff + 1'b1;
         if (cmd.scale)
            part_ff <= 2'd0;
         else if (cmd.part)
            part_ff <= part_ff + 2'd1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_lon_ff  <= in_lon;
         item_lat_ff  <= in_lat;
         item_last_ff <= in_last;
      end
      if (cmd.cos_start) begin
         origin_lon_ff <= item_lon_ff;
         origin_lat_ff <= item_lat_ff;
         prev_dlon_ff  <= '0;
         prev_dlat_ff  <= '0;
         x_ff          <= signed'(20'(gpas_pkg::CORDIC_X0));
         y_ff          <= '0;
         z_ff          <= z_start;
      end else if (cmd.cos_step) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         if (step_ff == STEP_LAST)
            origin_cos_ff <= cos_clamp;
      end
      if (cmd.mul) begin
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         prev_dlon_ff <= dlon;
         prev_dlat_ff <= dlat;
      end
      if (cmd.combine) begin
         cn_ff <= cn_in;
         cm_ff <= cm_in;
      end
      if (cmd.scale) begin
         f_ff   <= gpas_pkg::AREA_K * origin_cos_ff;
         acc_ff <= '0;
      end else if (cmd.part) begin
         acc_ff <= acc_ff + prod_sh;
      end
      if (cmd.rsp_load) begin
         rsp_area_ff   <= rsp_area_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // status to controller
   assign sts.first_vertex = first_ff;
   assign sts.last_vertex  = item_last_ff;
   assign sts.short_poly   = (vcount_ff != 2'd3);
   assign sts.cos_done     = (step_ff == STEP_LAST);
   assign sts.part_done    = (part_ff == 2'd3);
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_area   = rsp_area_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: rtl/gpas_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpas_controller
// sequencer for vertex intake, cosine, shoelace update and area scaling
// ----------------------------------------------------------------------------
module gpas_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gpas_pkg::gpas_sts_type sts,
   output gpas_pkg::gpas_cmd_type cmd
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_START = 10'b0000000010,
      ST_COS   = 10'b0000000100,
      ST_MUL   = 10'b0000001000,
      ST_CMB   = 10'b0000010000,
      ST_ACC   = 10'b0000100000,
      ST_CHECK = 10'b0001000000,
      ST_SCALE = 10'b0010000000,
      ST_PART  = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_START;
         ST_START: state_in = sts.first_vertex ? ST_COS : ST_MUL;
         ST_COS:   if (sts.cos_done) state_in = ST_CHECK;
         ST_MUL:   state_in = ST_CMB;
         ST_CMB:   state_in = ST_ACC;
         ST_ACC:   state_in = ST_CHECK;
         ST_CHECK: begin
            if (!sts.last_vertex)
               state_in = ST_IDLE;
            else if (sts.short_poly)
               state_in = ST_OUT;
            else
               state_in = ST_SCALE;
         end
         ST_SCALE: state_in = ST_PART;
         ST_PART:  if (sts.part_done) state_in = ST_OUT;
         ST_OUT:   if (sts.rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // commands
   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.capture   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.cos_start = (state_ff == ST_START) && sts.first_vertex;
   assign cmd.cos_step  = (state_ff == ST_COS);
   assign cmd.mul       = (state_ff == ST_MUL);
   assign cmd.combine   = (state_ff == ST_CMB);
   assign cmd.accum     = (state_ff == ST_ACC);
   assign cmd.scale     = (state_ff == ST_SCALE);
   assign cmd.part      = (state_ff == ST_PART);
   assign cmd.rsp_load  = (state_ff == ST_OUT) && sts.rsp_free;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// polygon area core: streamed vertices in, area and status beats out
// ----------------------------------------------------------------------------
// A directed table covers short rings, flat rings, extreme coordinates and a
// ring that drives the cross-product sum into saturation. Random polygons
// follow, most of them small local rings and some spanning the globe. Every
// result beat is compared against an in-bench model of the vertex arithmetic
// or a typed result of a directed row, under three idle patterns on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int  NUM_ITEMS   = 1100;
   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  DRAIN_WAIT  = 60;
   localparam int  STEPS       = gpas_pkg::COS_STEPS_DEF;
   localparam longint LON_SPAN = 64'sd1800000000;
   localparam longint LAT_SPAN = 64'sd900000000;

   typedef struct {
      logic [49:0] area;
      logic [1:0]  status;
   } area_beat_type;

   // one directed vertex, with a typed result where it is obvious
   typedef struct {
      longint      lon;
      longint      lat;
      bit          last;
      bit          typed;
      logic [49:0] area;
      logic [1:0]  status;
   } vertex_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   area_beat_type area_q[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          error_count;
   int          cycle_count;
   int          vertex_count_sent;
   int          polygon_count;
   int          short_count;
   int          overflow_count;

   // model state of the polygon in progress
   longint      org_lon;
   longint      org_lat;
   longint      prv_dlon;
   longint      prv_dlat;
   longint      ring_sum;
   int          ring_len;
   bit          sum_clipped;
   logic [17:0] org_cos;

   vertex_row_type dir_rows[$];

   geo_polygon_area_shoelace_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // cordic cosine of a latitude, degree domain, q1.17 clamped to 18 bits
   function automatic logic [17:0] lat_cosine(input longint lat);
      longint a;
      longint x;
      longint y;
      longint z;
      longint nx;
      a = (lat < 0) ? -lat : lat;
      if (a > 64'sd900000000) a = 64'sd1800000000 - a;
      x = longint'(gpas_pkg::CORDIC_X0);
      y = 0;
      z = a;
      for (int i = 0; i < STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(gpas_pkg::atan_deg7(i[4:0]));
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(gpas_pkg::atan_deg7(i[4:0]));
         end
         x = nx;
      end
      if (x < 0) x = 0;
      if (x > 262143) x = 262143;
      return x[17:0];
   endfunction

   // sign-magnitude add, a magnitude carry saturates to all ones
   function automatic logic [63:0] signmag_add(input bit an, input logic [63:0] am,
                                               input bit bn, input logic [63:0] bm,
                                               output bit rn);
      logic [64:0] s;
      if (an == bn) begin
         s  = {1'b0, am} + {1'b0, bm};
         rn = an;
         return s[64] ? {64{1'b1}} : s[63:0];
      end
      if (am >= bm) begin
         rn = an;
         return am - bm;
      end
      rn = bn;
      return bm - am;
   endfunction

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic void clear_ring();
      org_lon     = 0;
      org_lat     = 0;
      prv_dlon    = 0;
      prv_dlat    = 0;
      ring_sum    = 0;
      ring_len    = 0;
      sum_clipped = 0;
      org_cos     = '0;
   endfunction

   // advance the ring by one vertex; returns 1 with the result on a closing one
   function automatic bit fold_vertex(input longint lon, input longint lat, input bit last,
                                      output area_beat_type res);
      longint       dlon;
      longint       dlat;
      longint       p1;
      longint       p2;
      bit           cn;
      bit           sn;
      logic [63:0]  cm;
      logic [63:0]  sm;
      logic [63:0]  clip;
      logic [127:0] prod;
      logic [63:0]  area;
      clip = 64'h7FFF_FFFF_FFFF_FFFF;
      res  = '{area: '0, status: gpas_pkg::STATUS_OK};
      if (ring_len == 0) begin
         org_lon     = lon;
         org_lat     = lat;
         org_cos     = lat_cosine(lat);
         prv_dlon    = 0;
         prv_dlat    = 0;
         ring_sum    = 0;
         sum_clipped = 0;
      end else begin
         dlon = lon - org_lon;
         dlat = lat - org_lat;
         p1   = prv_dlat * dlon;
         p2   = dlat * prv_dlon;
         cm   = signmag_add(p1 < 0, magnitude(p1), p2 > 0, magnitude(p2), cn);
         sm   = signmag_add(ring_sum < 0, magnitude(ring_sum), cn, cm, sn);
         if (sm > clip) begin
            sm          = clip;
            sum_clipped = 1;
         end
         ring_sum = sn ? -longint'(sm) : longint'(sm);
         prv_dlon = dlon;
         prv_dlat = dlat;
      end
      if (ring_len < 3) ring_len++;
      if (!last) return 0;
      if (ring_len < 3) begin
         res.status = gpas_pkg::STATUS_SHORT;
      end else begin
         prod = 128'(magnitude(ring_sum)) *
                (128'(gpas_pkg::AREA_K) * 128'(org_cos));
         area = prod[126:63];
         if (area > 64'(gpas_pkg::AREA_MAX)) area = 64'(gpas_pkg::AREA_MAX);
         res.area   = area[49:0];
         res.status = sum_clipped ? gpas_pkg::STATUS_OVERFLOW : gpas_pkg::STATUS_OK;
      end
      clear_ring();
      return 1;
   endfunction

   // offer one vertex beat and queue its result once it is taken
   task automatic send_vertex(input longint lon, input longint lat, input bit last,
                              input bit typed, input area_beat_type typed_res);
      area_beat_type res;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, lat[30:0], lon[31:0]};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      vertex_count_sent++;
      if (fold_vertex(lon, lat, last, res)) begin
         area_q.push_back(typed ? typed_res : res);
         polygon_count++;
         if (res.status == gpas_pkg::STATUS_SHORT) short_count++;
         if (res.status == gpas_pkg::STATUS_OVERFLOW) overflow_count++;
      end
   endtask

   function automatic longint clamp_span(input longint v, input longint span);
      if (v > span) return span;
      if (v < -span) return -span;
      return v;
   endfunction

   function automatic longint rand_lon();
      return longint'($urandom_range(32'd3600000000)) - LON_SPAN;
   endfunction

   function automatic longint rand_lat();
      return longint'($urandom_range(32'd1800000000)) - LAT_SPAN;
   endfunction

   // one random polygon, mostly a small local ring
   task automatic send_random_polygon();
      int            n;
      int            reach;
      bit            wide;
      longint        base_lon;
      longint        base_lat;
      longint        lon;
      longint        lat;
      area_beat_type none;
      none  = '{area: '0, status: gpas_pkg::STATUS_OK};
      n     = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      wide  = ($urandom_range(4) == 0);
      reach = ($urandom_range(3) == 0) ? 50000000 : 2000000;
      base_lon = rand_lon();
      base_lat = rand_lat();
      for (int k = 0; k < n; k++) begin
         if (wide) begin
            lon = ($urandom_range(3) == 0) ? (($urandom_range(1) != 0) ? LON_SPAN : -LON_SPAN)
                                           : rand_lon();
            lat = ($urandom_range(3) == 0) ? (($urandom_range(1) != 0) ? LAT_SPAN : -LAT_SPAN)
                                           : rand_lat();
         end else begin
            lon = clamp_span(base_lon + $urandom_range(2 * reach) - reach, LON_SPAN);
            lat = clamp_span(base_lat + $urandom_range(2 * reach) - reach, LAT_SPAN);
         end
         send_vertex(lon, lat, k == n - 1, 0, none);
      end
   endtask

   function automatic void add_row(input longint lon, input longint lat, input bit last,
                                   input bit typed, input logic [49:0] area,
                                   input logic [1:0] status);
      dir_rows.push_back('{lon: lon, lat: lat, last: last, typed: typed,
                           area: area, status: status});
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result beat checker
   always @(posedge clock) begin
      area_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (area_q.size() == 0) begin
            $error("result beat with none expected: area %0d status %0d",
                   rsp_tdata[49:0], rsp_tuser);
            error_count++;
         end else begin
            want = area_q.pop_front();
            if (rsp_tdata[49:0] !== want.area) begin
               $error("area_sq_m: expected %0d, actual %0d", want.area, rsp_tdata[49:0]);
               error_count++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count, area_q.size());
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      area_beat_type typed_res;
      int            target;
      bit            held;
      error_count       = 0;
      cycle_count       = 0;
      vertex_count_sent = 0;
      polygon_count     = 0;
      short_count       = 0;
      overflow_count    = 0;
      held              = 1'b0;
      send_idle_pct     = 22;
      recv_idle_pct     = 57;
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tlast         = 1'b0;
      rsp_tready        = 1'b0;
      clear_ring();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single vertex ring, two vertex ring
      add_row(LON_SPAN, LAT_SPAN, 1, 1, '0, gpas_pkg::STATUS_SHORT);
      add_row(-LON_SPAN, -LAT_SPAN, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(LON_SPAN, LAT_SPAN, 1, 1, '0, gpas_pkg::STATUS_SHORT);
      // three identical vertices, zero area
      add_row(123456789, -45678901, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(123456789, -45678901, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(123456789, -45678901, 1, 1, '0, gpas_pkg::STATUS_OK);
      // small square near the equator
      add_row(0, 0, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(10000, 0, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(10000, 10000, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(0, 10000, 1, 0, '0, gpas_pkg::STATUS_OK);
      // accumulator saturation: repeated corner sweep from the far west
      add_row(-LON_SPAN, 0, 0, 0, '0, gpas_pkg::STATUS_OK);
      for (int r = 0; r < 3; r++) begin
         add_row(LON_SPAN, 0, 0, 0, '0, gpas_pkg::STATUS_OK);
         add_row(-LON_SPAN, LAT_SPAN, 0, 0, '0, gpas_pkg::STATUS_OK);
         add_row(-LON_SPAN, 0, r == 2, 0, '0, gpas_pkg::STATUS_OK);
      end
      // world-spanning triangle from the south pole
      add_row(LON_SPAN, -LAT_SPAN, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(-LON_SPAN, LAT_SPAN, 0, 0, '0, gpas_pkg::STATUS_OK);
      add_row(LON_SPAN, LAT_SPAN, 1, 0, '0, gpas_pkg::STATUS_OK);

      foreach (dir_rows[i]) begin
         typed_res = '{area: dir_rows[i].area, status: dir_rows[i].status};
         send_vertex(dir_rows[i].lon, dir_rows[i].lat, dir_rows[i].last,
                     dir_rows[i].typed, typed_res);
      end

      // three idle patterns over the random polygons
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 22 : (phase == 1) ? 57 : 0;
         recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 22 : 0;
         target = vertex_count_sent + NUM_ITEMS / 3;
         while (vertex_count_sent < target) begin
            send_random_polygon();
            // hold off once until the result side has caught up
            if (phase == 1 && !held && vertex_count_sent >= target - NUM_ITEMS / 6) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
               wait (area_q.size() == 0);
               held = 1'b1;
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      wait (area_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d vertex beats in %0d polygons", vertex_count_sent, polygon_count);
      $display("short rings %0d, saturated sums %0d, %0d cycles",
               short_count, overflow_count, cycle_count);
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
